[hw/rtl/hpt_pkg.sv]
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and constants for the climate sensor compensation pipeline.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int FRONT_STAGES = 12;
  localparam int BACK_STAGES  = 5;
  localparam int DIV_BITS     = 64;
  localparam int DIV_REM_W    = 31;
  localparam int ADDR_W       = 6;

  localparam logic [19:0] SKIP_WIDE = 20'h80000;
  localparam logic [15:0] SKIP_HUM  = 16'h8000;
  localparam logic [31:0] HUM_MAX   = 32'd419430400;

  localparam logic [2:0] REG_CAL_TEMP       = 3'd0;
  localparam logic [2:0] REG_CAL_PRESS_LOW  = 3'd1;
  localparam logic [2:0] REG_CAL_PRESS_HIGH = 3'd2;
  localparam logic [2:0] REG_CAL_PRESS_LAST = 3'd3;
  localparam logic [2:0] REG_CAL_HUM        = 3'd4;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;
  } hpt_in_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] temp_centi;
    logic [31:0]        pressure_q24_8;
    logic [16:0]        humidity_q22_10;
  } hpt_out_t;

  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_low;
    logic [63:0] press_high;
    logic [15:0] press_last;
    logic [63:0] hum;
  } hpt_cal_t;

  // fields riding along the divider chain
  typedef struct packed {
    logic        skip;
    logic        neg;
    logic        zero;
    logic [31:0] temp;
    logic [16:0] hum;
  } hpt_side_t;

  typedef struct packed {
    logic [DIV_REM_W-1:0] rem;
    logic [DIV_REM_W-1:0] dvs;
    logic [DIV_BITS-1:0]  dq;
    hpt_side_t            side;
  } hpt_div_t;

endpackage

[hw/rtl/humidity_pressure_temp_compensation_top.sv]
// ----------------------------------------------------------------------------
// humidity_pressure_temp_compensation_top
// Integer compensation of raw temperature, pressure and humidity readings.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data) carries one raw reading per
// transfer; output channel (out_valid/out_stall/out_data) returns one
// compensated result per reading, in order. Calibration words are written
// through the APB port (8-byte stride, pready tied high); the user must write
// them only while idle, the block does not enforce it. Throughput: one reading
// per cycle while the skid register is empty. A reading passes 12 front
// stages, 64 division cells (one quotient bit each) and 5 correction stages.
// A skid register behind the last stage catches a result that meets a
// stalled receiver; while it is full, the whole pipeline holds and in_stall
// is high. in_stall comes from a register, never from out_stall directly.
// Reset clears all valid bits, the skid-full flag and the calibration
// registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module humidity_pressure_temp_compensation_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  hpt_pkg::hpt_in_t            in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output hpt_pkg::hpt_out_t           out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hpt_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);
  import hpt_pkg::*;

  hpt_cal_t   cal;
  logic [2:0] reg_idx;
  logic       wr;
  logic       en;
  logic       skid_full;
  hpt_out_t   skid;
  logic       last_vld;
  hpt_out_t   last_data;

  logic [DIV_BITS:0] cvld;
  hpt_div_t          cdiv [DIV_BITS+1];

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:3];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (wr) begin
      unique case (reg_idx)
        REG_CAL_TEMP:       cal.temp       <= pwdata[47:0];
        REG_CAL_PRESS_LOW:  cal.press_low  <= pwdata;
        REG_CAL_PRESS_HIGH: cal.press_high <= pwdata;
        REG_CAL_PRESS_LAST: cal.press_last <= pwdata[15:0];
        REG_CAL_HUM:        cal.hum        <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CAL_TEMP:       prdata = {16'b0, cal.temp};
      REG_CAL_PRESS_LOW:  prdata = cal.press_low;
      REG_CAL_PRESS_HIGH: prdata = cal.press_high;
      REG_CAL_PRESS_LAST: prdata = {48'b0, cal.press_last};
      REG_CAL_HUM:        prdata = cal.hum;
      default:            prdata = 64'd0;
    endcase
  end

  // whole pipeline advances unless the skid register holds a result
  assign en       = !skid_full;
  assign in_stall = skid_full;

  hpt_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_valid),
    .in_data (in_data),
    .cal     (cal),
    .out_vld (cvld[0]),
    .out_div (cdiv[0])
  );

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_cell
    hpt_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (cvld[i]),
      .in_div  (cdiv[i]),
      .out_vld (cvld[i+1]),
      .out_div (cdiv[i+1])
    );
  end

  hpt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (cvld[DIV_BITS]),
    .in_div   (cdiv[DIV_BITS]),
    .cal      (cal),
    .out_vld  (last_vld),
    .out_data (last_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!out_stall) begin
        skid_full <= 1'b0;
      end
    end else if (last_vld && out_stall) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full && last_vld && out_stall) begin
      skid <= last_data;
    end
  end

  assign out_valid = skid_full || last_vld;
  assign out_data  = skid_full ? skid : last_data;

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_full && out_stall |=> skid_full && $stable(skid))
    else $error("skid register lost a stalled result");

  a_frozen: assert property (@(posedge clk) disable iff (rst)
    skid_full |=> $stable(last_vld) && (!last_vld || $stable(last_data)))
    else $error("pipeline moved while skid register was full");

  a_skid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(last_vld))
    else $error("skid register filled without a result");

  a_cal_wr: assert property (@(posedge clk) disable iff (rst)
    wr && reg_idx == REG_CAL_TEMP |=> cal.temp == $past(pwdata[47:0]))
    else $error("temperature calibration write not taken");

endmodule

[hw/rtl/hpt_front.sv]
// ----------------------------------------------------------------------------
// hpt_front
// Temperature, humidity and pressure pre-division pipeline (12 stages).
// ----------------------------------------------------------------------------
module hpt_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  hpt_pkg::hpt_in_t  in_data,
  input  hpt_pkg::hpt_cal_t cal,
  output logic             out_vld,
  output hpt_pkg::hpt_div_t out_div
);
  import hpt_pkg::*;

  localparam logic signed [12:0] PRESS_SCALE = 13'sd3125;

  logic [FRONT_STAGES-1:0] vld;

  // calibration fields
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, h2;
  logic [7:0]         h1, h3;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;

  assign t1 = cal.temp[15:0];
  assign t2 = $signed(cal.temp[31:16]);
  assign t3 = $signed(cal.temp[47:32]);
  assign p1 = cal.press_low[15:0];
  assign p2 = $signed(cal.press_low[31:16]);
  assign p3 = $signed(cal.press_low[47:32]);
  assign p4 = $signed(cal.press_low[63:48]);
  assign p5 = $signed(cal.press_high[15:0]);
  assign p6 = $signed(cal.press_high[31:16]);
  assign h1 = cal.hum[7:0];
  assign h2 = $signed(cal.hum[23:8]);
  assign h3 = cal.hum[31:24];
  assign h4 = $signed(cal.hum[43:32]);
  assign h5 = $signed(cal.hum[55:44]);
  assign h6 = $signed(cal.hum[63:56]);

  // stage 1
  logic signed [17:0] ta;
  logic signed [16:0] td;
  logic signed [33:0] ta_m, td_sq;
  logic               skip_w;
  logic signed [31:0] s1_m1, s1_dd;
  logic [19:0]        s1_ap;
  logic [15:0]        s1_ah;
  logic               s1_skip;

  assign ta    = $signed({1'b0, in_data.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign td    = $signed({1'b0, in_data.raw_temperature[19:4]}) - $signed({1'b0, t1});
  assign ta_m  = ta * t2;
  assign td_sq = td * td;
  assign skip_w = (in_data.raw_pressure == SKIP_WIDE) || (in_data.raw_temperature == SKIP_WIDE)
                  || (in_data.raw_humidity == SKIP_HUM);

  // stage 2
  logic signed [31:0] v1_w, dd_sh;
  logic signed [35:0] m2_w;
  logic signed [31:0] s2_v1, s2_m2;
  logic [19:0]        s2_ap;
  logic [15:0]        s2_ah;
  logic               s2_skip;

  assign v1_w  = s1_m1 >>> 11;
  assign dd_sh = s1_dd >>> 12;
  assign m2_w  = $signed(dd_sh[19:0]) * t3;

  // stage 3
  logic signed [31:0] v2_w, fine_w;
  logic signed [31:0] s3_fine;
  logic [19:0]        s3_ap;
  logic [15:0]        s3_ah;
  logic               s3_skip;

  assign v2_w   = s2_m2 >>> 14;
  assign fine_w = s2_v1 + v2_w;

  // stage 4
  logic signed [31:0] t5_w, temp_w, hv_w;
  logic signed [32:0] w1_w;
  logic signed [31:0] s4_temp, s4_hv;
  logic signed [32:0] s4_w1;
  logic [19:0]        s4_ap;
  logic [15:0]        s4_ah;
  logic               s4_skip;

  assign t5_w   = (s3_fine <<< 2) + s3_fine + 32'sd128;
  assign temp_w = t5_w >>> 8;
  assign w1_w   = $signed({s3_fine[31], s3_fine}) - 33'sd128000;
  assign hv_w   = s3_fine - 32'sd76800;

  // stage 5
  logic signed [65:0] w1sq_w;
  logic signed [48:0] w1p5_w, w1p2_w;
  logic signed [43:0] h5v_w;
  logic signed [39:0] vh6_w;
  logic signed [40:0] vh3_w;
  logic signed [63:0] s5_w1sq;
  logic signed [48:0] s5_w1p5, s5_w1p2;
  logic signed [31:0] s5_h5v, s5_vh6, s5_vh3, s5_temp;
  logic [19:0]        s5_ap;
  logic [15:0]        s5_ah;
  logic               s5_skip;

  assign w1sq_w = s4_w1 * s4_w1;
  assign w1p5_w = s4_w1 * p5;
  assign w1p2_w = s4_w1 * p2;
  assign h5v_w  = h5 * s4_hv;
  assign vh6_w  = s4_hv * h6;
  assign vh3_w  = s4_hv * $signed({1'b0, h3});

  // stage 6
  logic signed [79:0] w2a_w, w1b_w;
  logic signed [31:0] lsum_w, left_w, a6_w, vh3s_w, b6_w;
  logic signed [63:0] s6_w2a, s6_w1b;
  logic signed [48:0] s6_w1p5, s6_w1p2;
  logic signed [31:0] s6_left, s6_a6, s6_b6, s6_temp;
  logic [19:0]        s6_ap;
  logic               s6_skip;

  assign w2a_w  = s5_w1sq * p6;
  assign w1b_w  = s5_w1sq * p3;
  assign lsum_w = $signed({2'b0, s5_ah, 14'b0}) - $signed({h4, 20'b0}) - s5_h5v + 32'sd16384;
  assign left_w = lsum_w >>> 15;
  assign a6_w   = s5_vh6 >>> 10;
  assign vh3s_w = s5_vh3 >>> 11;
  assign b6_w   = vh3s_w + 32'sd32768;

  // stage 7
  logic signed [63:0] w1p5_64, w1p2_64, p4_35, w2_w, w1b_sh, w1c_w;
  logic signed [63:0] m7_w;
  logic signed [63:0] s7_w2, s7_w1c;
  logic signed [31:0] s7_m7, s7_left, s7_temp;
  logic [19:0]        s7_ap;
  logic               s7_skip;

  assign w1p5_64 = $signed({{15{s6_w1p5[48]}}, s6_w1p5});
  assign w1p2_64 = $signed({{15{s6_w1p2[48]}}, s6_w1p2});
  assign p4_35   = $signed({{13{p4[15]}}, p4, 35'b0});
  assign w2_w    = s6_w2a + (w1p5_64 <<< 17) + p4_35;
  assign w1b_sh  = s6_w1b >>> 8;
  assign w1c_w   = w1b_sh + (w1p2_64 <<< 12);
  assign m7_w    = s6_a6 * s6_b6;

  // stage 8
  logic signed [63:0] w1e_w, num_w;
  logic signed [80:0] w1d_w;
  logic [20:0]        pp_w;
  logic signed [31:0] inner_w, inner2_w;
  logic signed [47:0] r8_w;
  logic signed [63:0] s8_w1d, s8_num;
  logic signed [31:0] s8_r8, s8_left, s8_temp;
  logic               s8_skip;

  assign w1e_w    = s7_w1c + 64'sh0000_8000_0000_0000;
  assign w1d_w    = w1e_w * $signed({1'b0, p1});
  assign pp_w     = 21'd1048576 - {1'b0, s7_ap};
  assign num_w    = $signed({12'b0, pp_w, 31'b0}) - s7_w2;
  assign inner_w  = s7_m7 >>> 10;
  assign inner2_w = inner_w + 32'sd2097152;
  assign r8_w     = inner2_w * h2;

  // stage 9
  logic signed [63:0] dvs_full;
  logic signed [76:0] n3125_w;
  logic signed [31:0] r9s_w, right_w;
  logic signed [63:0] hv2_w;
  logic signed [30:0] s9_dvs;
  logic signed [63:0] s9_num;
  logic signed [31:0] s9_hv2, s9_temp;
  logic               s9_skip;

  assign dvs_full = s8_w1d >>> 33;
  assign n3125_w  = s8_num * PRESS_SCALE;
  assign r9s_w    = s8_r8 + 32'sd8192;
  assign right_w  = r9s_w >>> 14;
  assign hv2_w    = s8_left * right_w;

  // stage 10: magnitudes for the divider, humidity square
  logic signed [31:0] s_w;
  logic signed [63:0] ss_w;
  logic [63:0]        ma_w;
  logic [30:0]        mb_w;
  logic [63:0]        s10_ma, s11_ma;
  logic [30:0]        s10_mb, s11_mb;
  logic               s10_neg, s10_zero, s11_neg, s11_zero;
  logic signed [31:0] s10_ss, s10_hv2, s10_temp;
  logic               s10_skip;

  assign ma_w = s9_num[63] ? (64'd0 - s9_num) : s9_num;
  assign mb_w = s9_dvs[30] ? (31'd0 - s9_dvs) : s9_dvs;
  assign s_w  = s9_hv2 >>> 15;
  assign ss_w = s_w * s_w;

  // stage 11
  logic signed [31:0] ss_sh;
  logic signed [40:0] hp_w;
  logic signed [31:0] s11_hp, s11_hv2, s11_temp;
  logic               s11_skip;

  assign ss_sh = s10_ss >>> 7;
  assign hp_w  = ss_sh * $signed({1'b0, h1});

  // stage 12: clamp
  logic signed [31:0] hp_sh, hv3_w;
  logic [31:0]        hv_clamp;

  assign hp_sh = s11_hp >>> 4;
  assign hv3_w = s11_hv2 - hp_sh;

  always_comb begin
    if (hv3_w[31]) begin
      hv_clamp = 32'd0;
    end else if (hv3_w > HUM_MAX) begin
      hv_clamp = HUM_MAX;
    end else begin
      hv_clamp = hv3_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[FRONT_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m1   <= ta_m[31:0];
      s1_dd   <= td_sq[31:0];
      s1_ap   <= in_data.raw_pressure;
      s1_ah   <= in_data.raw_humidity;
      s1_skip <= skip_w;

      s2_v1   <= v1_w;
      s2_m2   <= m2_w[31:0];
      s2_ap   <= s1_ap;
      s2_ah   <= s1_ah;
      s2_skip <= s1_skip;

      s3_fine <= fine_w;
      s3_ap   <= s2_ap;
      s3_ah   <= s2_ah;
      s3_skip <= s2_skip;

      s4_temp <= temp_w;
      s4_w1   <= w1_w;
      s4_hv   <= hv_w;
      s4_ap   <= s3_ap;
      s4_ah   <= s3_ah;
      s4_skip <= s3_skip;

      s5_w1sq <= w1sq_w[63:0];
      s5_w1p5 <= w1p5_w;
      s5_w1p2 <= w1p2_w;
      s5_h5v  <= h5v_w[31:0];
      s5_vh6  <= vh6_w[31:0];
      s5_vh3  <= vh3_w[31:0];
      s5_temp <= s4_temp;
      s5_ap   <= s4_ap;
      s5_ah   <= s4_ah;
      s5_skip <= s4_skip;

      s6_w2a  <= w2a_w[63:0];
      s6_w1b  <= w1b_w[63:0];
      s6_w1p5 <= s5_w1p5;
      s6_w1p2 <= s5_w1p2;
      s6_left <= left_w;
      s6_a6   <= a6_w;
      s6_b6   <= b6_w;
      s6_temp <= s5_temp;
      s6_ap   <= s5_ap;
      s6_skip <= s5_skip;

      s7_w2   <= w2_w;
      s7_w1c  <= w1c_w;
      s7_m7   <= m7_w[31:0];
      s7_left <= s6_left;
      s7_temp <= s6_temp;
      s7_ap   <= s6_ap;
      s7_skip <= s6_skip;

      s8_w1d  <= w1d_w[63:0];
      s8_num  <= num_w;
      s8_r8   <= r8_w[31:0];
      s8_left <= s7_left;
      s8_temp <= s7_temp;
      s8_skip <= s7_skip;

      s9_dvs  <= dvs_full[30:0];
      s9_num  <= n3125_w[63:0];
      s9_hv2  <= hv2_w[31:0];
      s9_temp <= s8_temp;
      s9_skip <= s8_skip;

      s10_ma   <= ma_w;
      s10_mb   <= mb_w;
      s10_neg  <= s9_num[63] ^ s9_dvs[30];
      s10_zero <= (s9_dvs == 31'sd0);
      s10_ss   <= ss_w[31:0];
      s10_hv2  <= s9_hv2;
      s10_temp <= s9_temp;
      s10_skip <= s9_skip;

      s11_ma   <= s10_ma;
      s11_mb   <= s10_mb;
      s11_neg  <= s10_neg;
      s11_zero <= s10_zero;
      s11_hp   <= hp_w[31:0];
      s11_hv2  <= s10_hv2;
      s11_temp <= s10_temp;
      s11_skip <= s10_skip;

      out_div.rem       <= '0;
      out_div.dvs       <= s11_mb;
      out_div.dq        <= s11_ma;
      out_div.side.skip <= s11_skip;
      out_div.side.neg  <= s11_neg;
      out_div.side.zero <= s11_zero;
      out_div.side.temp <= s11_temp;
      out_div.side.hum  <= hv_clamp[28:12];
    end
  end

  assign out_vld = vld[FRONT_STAGES-1];

endmodule

[hw/rtl/hpt_div_cell.sv]
// ----------------------------------------------------------------------------
// hpt_div_cell
// One restoring-division cell: settles one quotient bit per cycle while en is high.
// ----------------------------------------------------------------------------
module hpt_div_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  hpt_pkg::hpt_div_t in_div,
  output logic             out_vld,
  output hpt_pkg::hpt_div_t out_div
);
  import hpt_pkg::*;

  logic [DIV_REM_W:0] trial, diff;
  logic               fits;

  // dividend bits leave at the top of dq, quotient bits enter at the bottom
  assign trial = {in_div.rem, in_div.dq[DIV_BITS-1]};
  assign diff  = trial - {1'b0, in_div.dvs};
  assign fits  = trial >= {1'b0, in_div.dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_div.rem  <= fits ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
      out_div.dvs  <= in_div.dvs;
      out_div.dq   <= {in_div.dq[DIV_BITS-2:0], fits};
      out_div.side <= in_div.side;
    end
  end

endmodule

[hw/rtl/hpt_back.sv]
// ----------------------------------------------------------------------------
// hpt_back
// Pressure post-division correction and result assembly (5 stages).
// ----------------------------------------------------------------------------
module hpt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  hpt_pkg::hpt_div_t  in_div,
  input  hpt_pkg::hpt_cal_t  cal,
  output logic              out_vld,
  output hpt_pkg::hpt_out_t  out_data
);
  import hpt_pkg::*;

  logic [BACK_STAGES-1:0] vld;
  logic signed [15:0]     p7, p8, p9;

  assign p7 = $signed(cal.press_high[47:32]);
  assign p8 = $signed(cal.press_high[63:48]);
  assign p9 = $signed(cal.press_last);

  // stage 1: signed quotient
  logic signed [63:0] p_w;
  logic signed [63:0] b1_p;
  hpt_side_t          b1_side;

  assign p_w = in_div.side.neg ? (64'd0 - in_div.dq) : in_div.dq;

  // stage 2: ps*ps split into 32-bit partial products
  logic signed [63:0] x_w;
  logic [31:0]        lo_w, hi_w, lh_w;
  logic [63:0]        ll_w;
  logic signed [79:0] p8p_w;
  logic [63:0]        b2_ll;
  logic [31:0]        b2_lh;
  logic signed [63:0] b2_p8p, b2_p;
  hpt_side_t          b2_side;

  assign x_w   = b1_p >>> 13;
  assign lo_w  = x_w[31:0];
  assign hi_w  = x_w[63:32];
  assign ll_w  = {32'b0, lo_w} * {32'b0, lo_w};
  assign lh_w  = lo_w * hi_w;
  assign p8p_w = b1_p * p8;

  // stage 3
  logic [63:0]        sq_w;
  logic signed [63:0] a2_w;
  logic [63:0]        b3_sq;
  logic signed [63:0] b3_a2, b3_p;
  hpt_side_t          b3_side;

  assign sq_w = b2_ll + {b2_lh[30:0], 33'b0};
  assign a2_w = b2_p8p >>> 19;

  // stage 4
  logic signed [79:0] m9_w;
  logic signed [63:0] b4_m9, b4_a2, b4_p;
  hpt_side_t          b4_side;

  assign m9_w = $signed(b3_sq) * p9;

  // stage 5
  logic signed [63:0] a1_w, sum_w, sh_w, p7_4, press_w;

  assign a1_w    = b4_m9 >>> 25;
  assign sum_w   = b4_p + a1_w + b4_a2;
  assign sh_w    = sum_w >>> 8;
  assign p7_4    = $signed({{44{p7[15]}}, p7, 4'b0});
  assign press_w = sh_w + p7_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[BACK_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_p    <= p_w;
      b1_side <= in_div.side;

      b2_ll   <= ll_w;
      b2_lh   <= lh_w;
      b2_p8p  <= p8p_w[63:0];
      b2_p    <= b1_p;
      b2_side <= b1_side;

      b3_sq   <= sq_w;
      b3_a2   <= a2_w;
      b3_p    <= b2_p;
      b3_side <= b2_side;

      b4_m9   <= m9_w[63:0];
      b4_a2   <= b3_a2;
      b4_p    <= b3_p;
      b4_side <= b3_side;

      if (b4_side.skip) begin
        out_data <= '{status: 1'b1, temp_centi: 32'sd0, pressure_q24_8: 32'd0,
                      humidity_q22_10: 17'd0};
      end else begin
        out_data.status          <= 1'b0;
        out_data.temp_centi      <= $signed(b4_side.temp);
        out_data.pressure_q24_8  <= b4_side.zero ? 32'd0 : press_w[31:0];
        out_data.humidity_q22_10 <= b4_side.hum;
      end
    end
  end

  assign out_vld = vld[BACK_STAGES-1];

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the climate sensor compensation pipeline: programs
// calibration sets over APB, drives directed and random raw readings with
// random gaps and stalls, and compares every result against an in-bench
// integer compensation computed from the current calibration.
// ----------------------------------------------------------------------------
module tb;
  import hpt_pkg::*;

  localparam int LATENCY     = 81;
  localparam int CYCLE_LIMIT = 1500000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  hpt_in_t           in_data;
  logic              out_valid;
  logic              out_stall;
  hpt_out_t          out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [63:0]       pwdata;
  logic [63:0]       prdata;
  logic              pready;

  humidity_pressure_temp_compensation_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // calibration mirror
  logic [47:0] cal_t;
  logic [63:0] cal_pl;
  logic [63:0] cal_ph;
  logic [15:0] cal_p9;
  logic [63:0] cal_h;

  hpt_out_t expected_q[$];
  int       errors;
  int       mismatches;
  int       cycles = 0;
  int       send_idle_pct;
  int       recv_stall_pct;
  bit       hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] asr32(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic hpt_out_t compensate(hpt_in_t r);
    hpt_out_t    o;
    logic [31:0] ap, at, ah, t1, t2, t3, v1, d, v2, fine, tmp;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, pr, p, ps, a1, a2;
    logic [63:0] na, nb;
    logic [31:0] h1, h2, h3, h4, h5, h6, v, lft, inr, rgt, s;
    o = '0;
    if (r.raw_pressure == SKIP_WIDE || r.raw_temperature == SKIP_WIDE ||
        r.raw_humidity == SKIP_HUM) begin
      o.status = 1'b1;
      return o;
    end
    ap = {12'd0, r.raw_pressure};
    at = {12'd0, r.raw_temperature};
    ah = {16'd0, r.raw_humidity};
    t1 = {16'd0, cal_t[15:0]};
    t2 = {{16{cal_t[31]}}, cal_t[31:16]};
    t3 = {{16{cal_t[47]}}, cal_t[47:32]};
    v1 = asr32(((at >> 3) - (t1 << 1)) * t2, 11);
    d = (at >> 4) - t1;
    v2 = asr32(asr32(d * d, 12) * t3, 14);
    fine = v1 + v2;
    tmp = asr32(fine * 32'd5 + 32'd128, 8);

    p1 = {48'd0, cal_pl[15:0]};
    p2 = {{48{cal_pl[31]}}, cal_pl[31:16]};
    p3 = {{48{cal_pl[47]}}, cal_pl[47:32]};
    p4 = {{48{cal_pl[63]}}, cal_pl[63:48]};
    p5 = {{48{cal_ph[15]}}, cal_ph[15:0]};
    p6 = {{48{cal_ph[31]}}, cal_ph[31:16]};
    p7 = {{48{cal_ph[47]}}, cal_ph[47:32]};
    p8 = {{48{cal_ph[63]}}, cal_ph[63:48]};
    p9 = {{48{cal_p9[15]}}, cal_p9};
    w1 = {{32{fine[31]}}, fine} - 64'd128000;
    w2 = w1 * w1 * p6;
    w2 = w2 + ((w1 * p5) << 17);
    w2 = w2 + (p4 << 35);
    w1 = asr64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
    w1 = asr64(((64'd1 << 47) + w1) * p1, 33);
    pr = '0;
    if (w1 != 0) begin
      p = 64'd1048576 - {32'd0, ap};
      p = ((p << 31) - w2) * 64'd3125;
      // truncating signed divide on magnitudes; min / -1 wraps
      na = p[63] ? -p : p;
      nb = w1[63] ? -w1 : w1;
      if (p[63] != w1[63]) p = -(na / nb);
      else p = na / nb;
      ps = asr64(p, 13);
      a1 = asr64(p9 * ps * ps, 25);
      a2 = asr64(p8 * p, 19);
      pr = asr64(p + a1 + a2, 8) + (p7 << 4);
    end

    h1 = {24'd0, cal_h[7:0]};
    h2 = {{16{cal_h[23]}}, cal_h[23:8]};
    h3 = {24'd0, cal_h[31:24]};
    h4 = {{20{cal_h[43]}}, cal_h[43:32]};
    h5 = {{20{cal_h[55]}}, cal_h[55:44]};
    h6 = {{24{cal_h[63]}}, cal_h[63:56]};
    v = fine - 32'd76800;
    lft = asr32((ah << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
    inr = asr32(asr32(v * h6, 10) * (asr32(v * h3, 11) + 32'd32768), 10);
    rgt = asr32((inr + 32'd2097152) * h2 + 32'd8192, 14);
    v = lft * rgt;
    s = asr32(v, 15);
    v = v - asr32(asr32(s * s, 7) * h1, 4);
    if (v[31]) v = '0;
    if (v > HUM_MAX) v = HUM_MAX;

    o.status = 1'b0;
    o.temp_centi = tmp;
    o.pressure_q24_8 = pr[31:0];
    o.humidity_q22_10 = v[28:12];
    return o;
  endfunction

  task automatic apb_write(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 3; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_CAL_TEMP:       cal_t  = val[47:0];
      REG_CAL_PRESS_LOW:  cal_pl = val;
      REG_CAL_PRESS_HIGH: cal_ph = val;
      REG_CAL_PRESS_LAST: cal_p9 = val[15:0];
      REG_CAL_HUM:        cal_h  = val;
      default: ;
    endcase
  endtask

  task automatic load_cal(logic [47:0] t, logic [63:0] pl, logic [63:0] ph,
                          logic [15:0] p9, logic [63:0] h);
    apb_write(REG_CAL_TEMP, {16'd0, t});
    apb_write(REG_CAL_PRESS_LOW, pl);
    apb_write(REG_CAL_PRESS_HIGH, ph);
    apb_write(REG_CAL_PRESS_LAST, {48'd0, p9});
    apb_write(REG_CAL_HUM, h);
  endtask

  // typical datasheet-like calibration
  task automatic load_typical();
    load_cal({16'hFC18, 16'd26435, 16'd27504},
             {16'd2855, 16'hD8BA, 16'd3024, 16'd36477},
             {16'd15500, 16'hC3C8, 16'hFFF9, 16'd140},
             16'd6000,
             {8'd30, 12'd50, 12'd300, 8'd0, 16'd360, 8'd75});
  endtask

  task automatic load_random();
    load_cal({$urandom, $urandom} & 48'hFFFF_FFFF_FFFF, {$urandom, $urandom},
             {$urandom, $urandom}, 16'($urandom), {$urandom, $urandom});
  endtask

  // one transfer; optional idle before it, valid stays up for a following one
  task automatic send(hpt_in_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(compensate(r));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic hpt_in_t rand_reading();
    hpt_in_t r;
    r.raw_pressure    = 20'($urandom);
    r.raw_temperature = 20'($urandom);
    r.raw_humidity    = 16'($urandom);
    case ($urandom_range(19))
      0: r.raw_pressure    = SKIP_WIDE;
      1: r.raw_temperature = SKIP_WIDE;
      2: r.raw_humidity    = SKIP_HUM;
      3, 4, 5, 6, 7, 8, 9, 10: begin
        // realistic span
        r.raw_pressure    = 20'($urandom_range(250000, 450000));
        r.raw_temperature = 20'($urandom_range(400000, 600000));
        r.raw_humidity    = 16'($urandom_range(20000, 40000));
      end
      default: ;
    endcase
    return r;
  endfunction

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    hpt_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("unexpected result %h", out_data);
      end else begin
        want = expected_q.pop_front();
        if (out_data !== want) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected st=%0d t=%0d p=%h h=%0d, got st=%0d t=%0d p=%h h=%0d",
                     want.status, want.temp_centi, want.pressure_q24_8,
                     want.humidity_q22_10, out_data.status, out_data.temp_centi,
                     out_data.pressure_q24_8, out_data.humidity_q22_10);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  typedef struct {
    hpt_in_t  r;
    bit       fixed;
    hpt_out_t res;
  } stim_row_t;

  stim_row_t directed[$];

  initial begin
    hpt_in_t r;
    int      ph;
    errors = 0; mismatches = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 1'b0;
    rst = 1'b1; in_valid = 1'b0; in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cal_t = '0; cal_pl = '0; cal_ph = '0; cal_p9 = '0; cal_h = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // after reset: all-zero calibration, divisor zero -> pressure 0
    directed.push_back('{'{20'd0, 20'd0, 16'd0}, 1'b1,
                         '{1'b0, 32'sd0, 32'd0, 17'd0}});
    directed.push_back('{'{SKIP_WIDE, 20'd5, 16'd5}, 1'b1, '{1'b1, 32'sd0, 32'd0, 17'd0}});
    directed.push_back('{'{20'd5, SKIP_WIDE, 16'd5}, 1'b1, '{1'b1, 32'sd0, 32'd0, 17'd0}});
    directed.push_back('{'{20'd5, 20'd5, SKIP_HUM}, 1'b1, '{1'b1, 32'sd0, 32'd0, 17'd0}});
    directed.push_back('{'{20'hFFFFF, 20'hFFFFF, 16'hFFFF}, 1'b0, '0});
    directed.push_back('{'{20'h7FFFF, 20'h80001, 16'h7FFF}, 1'b0, '0});
    foreach (directed[i]) begin
      send(directed[i].r);
      if (directed[i].fixed && expected_q[$] !== directed[i].res) begin
        errors++;
        $display("directed row %0d: table disagrees with prediction", i);
      end
    end
    drain();

    load_typical();
    for (int i = 0; i < 14; i++) begin
      r = rand_reading();
      if (i < 2) r = '{20'(i * 20'hFFFFF), 20'(i * 20'hFFFFF), 16'(i * 16'hFFFF)};
      if (i == 2) r = '{20'd415148, 20'd519888, 16'd30000};
      send(r);
    end
    drain();

    // extremes of the calibration words
    load_cal('1, '1, '1, '1, '1);
    for (int i = 0; i < 4; i++) send(rand_reading());
    drain();
    load_cal({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
             {4{16'h8000}}, 16'h8000, {8'h7F, 12'h800, 12'h7FF, 8'hFF, 16'h8000, 8'hFF});
    for (int i = 0; i < 4; i++) send(rand_reading());
    drain();

    for (ph = 0; ph < 8; ph++) begin
      if (ph % 2 == 0) load_typical(); else load_random();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      if (ph == 4) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < 170; i++) begin
        send(rand_reading());
        if (i == 80) begin
          in_valid <= 1'b0;
          while (expected_q.size() != 0) @(negedge clk);
        end
      end
      drain();
    end

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
